FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n
// in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: src/fq_pkg.sv
// ---------------------------------------------------------------------------
// fq_pkg
// Types, codes and constants of the FIFO queue with peek and dump.
// ---------------------------------------------------------------------------
package fq_pkg;

	// Default number of entries in the ring.
	localparam int DEPTH_DEF = 16;

	// Fixed field widths.
	localparam int DATA_W  = 32;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DISP = 2'd3;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	// Input word: one command.
	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [DATA_W-1:0] value;
	} fq_in_t;

	// Output word: one result.
	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] data;
		logic [COUNT_W-1:0]       count;
		logic                     last;
	} fq_out_t;

endpackage

FILE: src/fq_ram.sv
// ---------------------------------------------------------------------------
// fq_ram
// Entry storage: one write port, one read port with registered read data
// that holds its value until the next read.
// ---------------------------------------------------------------------------
module fq_ram
	import fq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [IDX_W-1:0]         wr_addr,
	input  logic signed [DATA_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [IDX_W-1:0]         rd_addr,
	output logic signed [DATA_W-1:0] rd_data
);

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data stays until the next read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/fifo_queue_with_peek_and_dump.sv
// ---------------------------------------------------------------------------
// fifo_queue_with_peek_and_dump
// Bounded FIFO queue of signed 32-bit words with peek and a full dump.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_word) carries one command per
// word: enqueue, dequeue, peek or display. The output channel (out_valid,
// out_ready, out_word) returns the results, each with a status, the data,
// the entry count after the command and a last flag.
// Enqueue and every error result appear in the cycle after the input word
// is taken, so enqueues run at one word per cycle while the receiver keeps
// up. Dequeue and peek read the entry memory into its read register, then
// into the output register; the next command is taken at the earliest in
// the cycle the result is presented.
// Display issues one memory read per held entry and emits one result per
// cycle while the receiver keeps up. The registered single read port of the
// entry memory sets this sequence.
// When the receiver stalls, the result waits in the output register and no
// new command is taken until that register can be reloaded.
// Reset empties the queue; entry contents are not cleared and are never
// read before being written.
// ---------------------------------------------------------------------------
module fifo_queue_with_peek_and_dump
	import fq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  fq_in_t  in_word,
	output logic    out_valid,
	input  logic    out_ready,
	output fq_out_t out_word
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Controller states.
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_DISP = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0] left_q, left_d;
	logic             out_valid_q;
	fq_out_t          out_word_q;

	logic                     out_free;
	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     out_load;
	fq_out_t                  res;
	logic                     wr_en;
	logic                     rd_en;
	logic [IDX_W-1:0]         rd_addr;
	logic signed [DATA_W-1:0] rd_data;

	// Ring index advance with wrap at the last entry.
	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
		if (i == IDX_W'(DEPTH - 1)) begin
			return '0;
		end
		return i + 1'b1;
	endfunction

	// Entry storage.
	fq_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail_q),
		.wr_data(in_word.value),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Handshake and occupancy flags.
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	// Command sequencing, pointer updates and result formation.
	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		rd_idx_d = rd_idx_q;
		left_d   = left_q;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = head_q;
		out_load = 1'b0;
		res      = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_word.command)
						CMD_ENQ: begin
							out_load = 1'b1;
							res.last = 1'b1;
							if (full) begin
								res.status = STAT_FULL;
								res.count  = COUNT_W'(count_q);
							end else begin
								wr_en      = 1'b1;
								tail_d     = idx_next(tail_q);
								count_d    = count_q + 1'b1;
								res.status = STAT_OK;
								res.data   = in_word.value;
								res.count  = COUNT_W'(count_d);
							end
						end
						CMD_DEQ, CMD_PEEK: begin
							if (empty) begin
								out_load   = 1'b1;
								res.status = STAT_EMPTY;
								res.last   = 1'b1;
							end else begin
								rd_en   = 1'b1;
								state_d = S_READ;
								if (in_word.command == CMD_DEQ) begin
									head_d  = idx_next(head_q);
									count_d = count_q - 1'b1;
								end
							end
						end
						CMD_DISP: begin
							if (empty) begin
								out_load   = 1'b1;
								res.status = STAT_EMPTY;
								res.last   = 1'b1;
							end else begin
								rd_en    = 1'b1;
								rd_idx_d = idx_next(head_q);
								left_d   = count_q;
								state_d  = S_DISP;
							end
						end
					endcase
				end
			end
			S_READ: begin
				// Head word is on the read port; count already reflects the command.
				if (out_free) begin
					out_load   = 1'b1;
					res.status = STAT_OK;
					res.data   = rd_data;
					res.count  = COUNT_W'(count_q);
					res.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_DISP: begin
				// Emit one entry per cycle while the output is free and fetch the following one.
				if (out_free) begin
					out_load   = 1'b1;
					res.status = STAT_OK;
					res.data   = rd_data;
					res.count  = COUNT_W'(count_q);
					res.last   = (left_q == CNT_W'(1));
					if (left_q == CNT_W'(1)) begin
						state_d = S_IDLE;
					end else begin
						rd_en    = 1'b1;
						rd_addr  = rd_idx_q;
						rd_idx_d = idx_next(rd_idx_q);
						left_d   = left_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			rd_idx_q <= rd_idx_d;
			left_q   <= left_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Checks.
	`include "assert_macros.svh"

	`ASSERT_NEVER(a_count_range, count_q > CNT_W'(DEPTH), "entry count above depth")
	`ASSERT_CLK(a_ptr_empty, (count_q == '0) |-> (head_q == tail_q), "pointers differ when empty")
	`ASSERT_CLK(a_count_hold, !(in_valid && in_ready) |=> $stable(count_q), "count moved without a command")
	`ASSERT_NEVER(a_disp_left, (state_q == S_DISP) && (left_q == '0), "display with nothing left")

endmodule
